/* rtl/three_point_colour_ramp_core_defines.svh */
// Assertion macros for the color ramp core.
// Included by rtl/three_point_colour_ramp_core.sv; expects i_clk and i_rst_n in scope.
`ifndef THREE_POINT_COLOUR_RAMP_CORE_DEFINES_SVH
`define THREE_POINT_COLOUR_RAMP_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TPCR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TPCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tpcr_pkg.sv */
// Types, constants and divider step functions for the color ramp core.
// No dependencies; imported by rtl/three_point_colour_ramp_core.sv.
`default_nettype none

package tpcr_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int POS_W           = FRAC_BITS + 1;
    localparam int PALETTE_ENTRIES = 256;
    localparam int LEN_W           = 9;
    localparam int NUM_W           = 8 + POS_W + 1;
    localparam int REM2_W          = POS_W;

    localparam int D1_STAGES  = 4;
    localparam int D1_STEPS   = FRAC_BITS / D1_STAGES;
    localparam int D2_STAGES  = 4;
    localparam int D2_STEPS   = 8 / D2_STAGES;
    localparam int ST_W       = D1_STAGES;
    localparam int ST_M       = D1_STAGES + 1;
    localparam int ST_D2      = D1_STAGES + 2;
    localparam int NUM_STAGES = D1_STAGES + 2 + D2_STAGES;

    localparam logic [POS_W-1:0] RAMP_ONE = POS_W'(1) << FRAC_BITS;

    localparam logic [23:0]      AMBIENT_RST  = 24'd0;
    localparam logic [23:0]      DIFFUSE_RST  = 24'd0;
    localparam logic [23:0]      SPECULAR_RST = 24'd0;
    localparam logic [16:0]      CUT_RST      = 17'(RAMP_ONE >> 1);
    localparam logic [LEN_W-1:0] LENGTH_RST   = LEN_W'(256);
    localparam logic [7:0]       BASE_RST     = 8'd0;

    typedef enum logic [2:0] {
        REG_AMBIENT  = 3'd0,
        REG_DIFFUSE  = 3'd1,
        REG_SPECULAR = 3'd2,
        REG_CUT      = 3'd3,
        REG_LENGTH   = 3'd4,
        REG_BASE     = 3'd5
    } t_reg_idx;

    // position divider stages
    typedef struct packed {
        logic [LEN_W-1:0]     len;
        logic [LEN_W-1:0]     rem;
        logic [FRAC_BITS-1:0] quo;
        logic                 ovf;
        logic [7:0]           idx;
        logic                 flag;
    } t_d1;

    // weight select stage
    typedef struct packed {
        logic [23:0]      c0;
        logic [23:0]      c1;
        logic [POS_W-1:0] w0;
        logic [POS_W-1:0] w1;
        logic [POS_W-1:0] span;
        logic [7:0]       idx;
        logic             flag;
    } t_w;

    // product stage
    typedef struct packed {
        logic [2:0][NUM_W-1:0] num;
        logic [23:0]           c0;
        logic [POS_W-1:0]      span;
        logic [7:0]            idx;
        logic                  flag;
    } t_m;

    typedef struct packed {
        logic [REM2_W-1:0] rem;
        logic [7:0]        low;
        logic [7:0]        q;
    } t_chan;

    // channel divider stages
    typedef struct packed {
        t_chan [2:0]      chan;
        logic [23:0]      c0;
        logic [POS_W-1:0] span;
        logic [7:0]       idx;
        logic             flag;
    } t_d2;

    function automatic t_d1 div1_step(input t_d1 s);
        t_d1          t;
        logic [LEN_W:0] rs;
        t = s;
        for (int i = 0; i < D1_STEPS; i++) begin
            rs = {t.rem, 1'b0};
            if (rs >= {1'b0, t.len}) begin
                t.rem = LEN_W'(rs - {1'b0, t.len});
                t.quo = {t.quo[FRAC_BITS-2:0], 1'b1};
            end else begin
                t.rem = rs[LEN_W-1:0];
                t.quo = {t.quo[FRAC_BITS-2:0], 1'b0};
            end
        end
        return t;
    endfunction

    function automatic t_chan div2_step(input t_chan c, input logic [POS_W-1:0] span);
        t_chan           t;
        logic [REM2_W:0] rs;
        t = c;
        for (int i = 0; i < D2_STEPS; i++) begin
            rs    = {t.rem, t.low[7]};
            t.low = {t.low[6:0], 1'b0};
            if (rs >= {1'b0, span}) begin
                t.rem = REM2_W'(rs - {1'b0, span});
                t.q   = {t.q[6:0], 1'b1};
            end else begin
                t.rem = rs[REM2_W-1:0];
                t.q   = {t.q[6:0], 1'b0};
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/three_point_colour_ramp_core.sv */
// Color ramp core: APB register file and a ten-stage pipeline that divides
// the offset into a ramp position, blends the channels and divides by the span.
// Depends on rtl/tpcr_pkg.sv and rtl/three_point_colour_ramp_core_defines.svh.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+------------------------------------
//  in      | in  | i_in_valid / o_in_stall    | i_entry_offset
//  out     | out | o_out_valid / i_out_stall  | o_palette_index, o_red, o_green,
//          |     |                            | o_blue, o_out_of_range
//  cfg     | in  | psel / penable / pready    | paddr, pwrite, pwdata, prdata
//
// One transaction per cycle sustained while i_out_stall stays low; the pipeline
// is 4 stages of the position divider at 4 quotient bits each, weight select,
// products and 4 stages of the channel dividers at 2 quotient bits each.
// Each stage moves when it is empty or the next stage moves, so bubbles close
// up under stall; o_in_stall rises only when all 10 stages hold transactions.
// Synchronous reset clears the stage valids and loads register defaults.
`default_nettype none

`include "three_point_colour_ramp_core_defines.svh"

module three_point_colour_ramp_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_entry_offset,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_palette_index,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic             o_out_of_range,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tpcr_pkg::*;

    logic [23:0]      r_ambient;
    logic [23:0]      r_diffuse;
    logic [23:0]      r_specular;
    logic [16:0]      r_cut;
    logic [LEN_W-1:0] r_length;
    logic [7:0]       r_base;

    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] n_v;
    logic [NUM_STAGES-1:0] adv;

    t_d1 r_d1 [D1_STAGES];
    t_d1 n_d1 [D1_STAGES];
    t_w  r_w;
    t_w  n_w;
    t_m  r_m;
    t_m  n_m;
    t_d2 r_d2 [D2_STAGES];
    t_d2 n_d2 [D2_STAGES];

    t_reg_idx         reg_sel;
    t_d1              d1_init;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] cut;
    logic             wr_en;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ambient  <= AMBIENT_RST;
            r_diffuse  <= DIFFUSE_RST;
            r_specular <= SPECULAR_RST;
            r_cut      <= CUT_RST;
            r_length   <= LENGTH_RST;
            r_base     <= BASE_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_AMBIENT:  r_ambient  <= pwdata[23:0];
                REG_DIFFUSE:  r_diffuse  <= pwdata[23:0];
                REG_SPECULAR: r_specular <= pwdata[23:0];
                REG_CUT:      r_cut      <= pwdata[16:0];
                REG_LENGTH:   r_length   <= pwdata[LEN_W-1:0];
                REG_BASE:     r_base     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_AMBIENT:  prdata = {8'd0, r_ambient};
            REG_DIFFUSE:  prdata = {8'd0, r_diffuse};
            REG_SPECULAR: prdata = {8'd0, r_specular};
            REG_CUT:      prdata = {15'd0, r_cut};
            REG_LENGTH:   prdata = {{(32 - LEN_W){1'b0}}, r_length};
            REG_BASE:     prdata = {24'd0, r_base};
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------- stage control ----------------
    always_comb begin
        adv[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || !i_out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
        n_v[0] = adv[0] ? i_in_valid : r_v[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_v[k] = adv[k] ? r_v[k-1] : r_v[k];
        end
    end

    assign o_in_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // ---------------- datapath ----------------
    always_comb begin
        d1_init.len  = r_length;
        d1_init.ovf  = ({1'b0, i_entry_offset} >= r_length);
        d1_init.rem  = d1_init.ovf ? '0 : LEN_W'(i_entry_offset);
        d1_init.quo  = '0;
        d1_init.idx  = r_base + i_entry_offset;
        d1_init.flag = d1_init.ovf ||
                       ((LEN_W + 1)'(r_base) + (LEN_W + 1)'(r_length) >
                        (LEN_W + 1)'(PALETTE_ENTRIES));
        n_d1[0] = div1_step(d1_init);
        for (int k = 1; k < D1_STAGES; k++) begin
            n_d1[k] = div1_step(r_d1[k-1]);
        end

        // segment select and weights
        pos = r_d1[D1_STAGES-1].ovf ? RAMP_ONE : {1'b0, r_d1[D1_STAGES-1].quo};
        cut = (r_cut > RAMP_ONE) ? RAMP_ONE : r_cut;
        n_w.idx  = r_d1[D1_STAGES-1].idx;
        n_w.flag = r_d1[D1_STAGES-1].flag;
        if (pos < cut) begin
            n_w.c0   = r_ambient;
            n_w.c1   = r_diffuse;
            n_w.w0   = cut - pos;
            n_w.w1   = pos;
            n_w.span = cut;
        end else begin
            n_w.c0   = r_diffuse;
            n_w.c1   = r_specular;
            n_w.w0   = RAMP_ONE - pos;
            n_w.w1   = pos - cut;
            n_w.span = RAMP_ONE - cut;
        end

        // weighted sums, channel 2 is red
        n_m.c0   = r_w.c0;
        n_m.span = r_w.span;
        n_m.idx  = r_w.idx;
        n_m.flag = r_w.flag;
        for (int k = 0; k < 3; k++) begin
            n_m.num[k] = NUM_W'(r_w.c0[8*k +: 8]) * NUM_W'(r_w.w0) +
                         NUM_W'(r_w.c1[8*k +: 8]) * NUM_W'(r_w.w1);
        end

        // channel dividers; the sum is below 256 * span, so 8 quotient bits
        n_d2[0].c0   = r_m.c0;
        n_d2[0].span = r_m.span;
        n_d2[0].idx  = r_m.idx;
        n_d2[0].flag = r_m.flag;
        for (int k = 0; k < 3; k++) begin
            n_d2[0].chan[k].rem = REM2_W'(r_m.num[k][NUM_W-1:8]);
            n_d2[0].chan[k].low = r_m.num[k][7:0];
            n_d2[0].chan[k].q   = '0;
            n_d2[0].chan[k]     = div2_step(n_d2[0].chan[k], r_m.span);
        end
        for (int s = 1; s < D2_STAGES; s++) begin
            n_d2[s] = r_d2[s-1];
            for (int k = 0; k < 3; k++) begin
                n_d2[s].chan[k] = div2_step(r_d2[s-1].chan[k], r_d2[s-1].span);
            end
        end
        // empty upper span: result is the lower color
        if (r_d2[D2_STAGES-2].span == '0) begin
            for (int k = 0; k < 3; k++) begin
                n_d2[D2_STAGES-1].chan[k].q = r_d2[D2_STAGES-2].c0[8*k +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < D1_STAGES; k++) begin
            if (adv[k]) begin
                r_d1[k] <= n_d1[k];
            end
        end
        if (adv[ST_W]) begin
            r_w <= n_w;
        end
        if (adv[ST_M]) begin
            r_m <= n_m;
        end
        for (int k = 0; k < D2_STAGES; k++) begin
            if (adv[ST_D2 + k]) begin
                r_d2[k] <= n_d2[k];
            end
        end
    end

    assign o_out_valid     = r_v[NUM_STAGES-1];
    assign o_palette_index = r_d2[D2_STAGES-1].idx;
    assign o_red           = r_d2[D2_STAGES-1].chan[2].q;
    assign o_green         = r_d2[D2_STAGES-1].chan[1].q;
    assign o_blue          = r_d2[D2_STAGES-1].chan[0].q;
    assign o_out_of_range  = r_d2[D2_STAGES-1].flag;

    // ---------------- assertions ----------------
    `TPCR_ASSERT_IMPL(a_stall_full, o_in_stall, &r_v, "input stalled with a free stage")
    `TPCR_ASSERT_IMPL(a_d1_rem,
        r_v[D1_STAGES-1] && !r_d1[D1_STAGES-1].ovf,
        r_d1[D1_STAGES-1].rem < r_d1[D1_STAGES-1].len,
        "position remainder not below length")
    `TPCR_ASSERT_IMPL(a_w_sum,
        r_v[ST_W],
        (POS_W + 1)'(r_w.w0) + (POS_W + 1)'(r_w.w1) == (POS_W + 1)'(r_w.span),
        "weights do not add up to span")
    `TPCR_ASSERT_IMPL(a_d2_rem,
        r_v[ST_D2] && (r_d2[0].span != '0),
        r_d2[0].chan[0].rem < r_d2[0].span,
        "channel remainder not below span")

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for three_point_colour_ramp_core: drives entry offsets and APB
// register writes, predicts every palette entry and compares in transaction order.
// Depends on rtl/tpcr_pkg.sv and the core; the scoreboard class lives in this file.
`timescale 1ns / 100ps

module testbench;
    import tpcr_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int PIPE_LATENCY   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 60;

    typedef struct packed {
        logic [7:0] palette_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       out_of_range;
    } t_entry;

    class ramp_scoreboard;
        logic [23:0]      ambient  = AMBIENT_RST;
        logic [23:0]      diffuse  = DIFFUSE_RST;
        logic [23:0]      specular = SPECULAR_RST;
        logic [16:0]      cut      = CUT_RST;
        logic [LEN_W-1:0] length   = LENGTH_RST;
        logic [7:0]       base     = BASE_RST;
        t_entry           expected_entries[$];
        int               errors  = 0;
        int               checked = 0;
        int               flagged = 0;

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_AMBIENT:  ambient  = value[23:0];
                REG_DIFFUSE:  diffuse  = value[23:0];
                REG_SPECULAR: specular = value[23:0];
                REG_CUT:      cut      = value[16:0];
                REG_LENGTH:   length   = value[LEN_W-1:0];
                REG_BASE:     base     = value[7:0];
                default: ;
            endcase
        endfunction

        function t_entry predict_entry(logic [7:0] offset);
            t_entry      e;
            logic [63:0] cut_c, pos, w0, w1, span, lo, hi;
            logic [23:0] c0, c1;
            logic [7:0]  chan [3];
            cut_c = (cut > RAMP_ONE) ? 64'(RAMP_ONE) : 64'(cut);
            if (length == 0)
                pos = 64'(RAMP_ONE);
            else
                pos = (64'(offset) << FRAC_BITS) / 64'(length);
            if (pos > 64'(RAMP_ONE))
                pos = 64'(RAMP_ONE);
            if (pos < cut_c) begin
                c0   = ambient;
                c1   = diffuse;
                w0   = cut_c - pos;
                w1   = pos;
                span = cut_c;
            end else begin
                c0   = diffuse;
                c1   = specular;
                w0   = 64'(RAMP_ONE) - pos;
                w1   = pos - cut_c;
                span = 64'(RAMP_ONE) - cut_c;
            end
            for (int k = 0; k < 3; k++) begin
                lo = 64'((c0 >> (16 - 8 * k)) & 24'hFF);
                hi = 64'((c1 >> (16 - 8 * k)) & 24'hFF);
                chan[k] = (span == 0) ? lo[7:0] : 8'((lo * w0 + hi * w1) / span);
            end
            e.palette_index = base + offset;
            e.red           = chan[0];
            e.green         = chan[1];
            e.blue          = chan[2];
            e.out_of_range  = (9'(offset) >= length) ||
                              (int'(base) + int'(length) > PALETTE_ENTRIES);
            return e;
        endfunction

        function void note_offset(logic [7:0] offset);
            t_entry e;
            e = predict_entry(offset);
            if (e.out_of_range)
                flagged++;
            expected_entries.push_back(e);
        endfunction

        function int pending();
            return expected_entries.size();
        endfunction

        task report_mismatch(string what, int got, int want, int idx);
            $display("MISMATCH %s: got 0x%0h expected 0x%0h (palette index %0d)",
                     what, got, want, idx);
            errors++;
        endtask

        task check_entry(t_entry got);
            t_entry want;
            if (expected_entries.size() == 0) begin
                report_mismatch("unexpected transaction", int'(got.palette_index), 0,
                                int'(got.palette_index));
                return;
            end
            want = expected_entries.pop_front();
            checked++;
            if (got.palette_index !== want.palette_index)
                report_mismatch("palette_index", got.palette_index, want.palette_index,
                                want.palette_index);
            if (got.red !== want.red)
                report_mismatch("red", got.red, want.red, want.palette_index);
            if (got.green !== want.green)
                report_mismatch("green", got.green, want.green, want.palette_index);
            if (got.blue !== want.blue)
                report_mismatch("blue", got.blue, want.blue, want.palette_index);
            if (got.out_of_range !== want.out_of_range)
                report_mismatch("out_of_range", got.out_of_range, want.out_of_range,
                                want.palette_index);
        endtask
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_entry_offset = 8'd0;
    logic        i_out_stall    = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [4:0]  paddr          = 5'd0;
    logic [31:0] pwdata         = 32'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_palette_index;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_out_of_range;
    logic [31:0] prdata;
    logic        pready;

    ramp_scoreboard sb;
    bit             calm     = 1'b0;
    int             settings = 0;

    three_point_colour_ramp_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_entry_offset  (i_entry_offset),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_palette_index (o_palette_index),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_out_of_range  (o_out_of_range),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_offset(logic [7:0] offset);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_entry_offset <= offset;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
        sb.note_offset(offset);
    endtask

    task automatic send_list(input int offsets[$]);
        foreach (offsets[i])
            send_offset(8'(offsets[i]));
    endtask

    task automatic drain_results();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk) penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready)
                break;
        end
        sb.set_reg(idx, value);
    endtask

    task automatic load_config(logic [31:0] amb, logic [31:0] dif, logic [31:0] spc,
                               logic [31:0] cut, logic [31:0] len, logic [31:0] base);
        write_reg(REG_AMBIENT, amb);
        write_reg(REG_DIFFUSE, dif);
        write_reg(REG_SPECULAR, spc);
        write_reg(REG_CUT, cut);
        write_reg(REG_LENGTH, len);
        write_reg(REG_BASE, base);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings++;
    endtask

    function automatic logic [31:0] upper_junk(int width);
        if ($urandom_range(0, 3) == 0)
            return ($urandom() >> width) << width;
        return 32'd0;
    endfunction

    function automatic logic [23:0] pick_colour();
        case ($urandom_range(0, 4))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [16:0] pick_cut();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return RAMP_ONE;
            2: return 17'h1FFFF;
            3: return 17'($urandom_range(int'(RAMP_ONE) + 1, 17'h1FFFF));
            default: return 17'($urandom_range(1, int'(RAMP_ONE) - 1));
        endcase
    endfunction

    task automatic random_config(output int len);
        int base;
        case ($urandom_range(0, 9))
            0: len = 0;
            1: len = 1;
            2: len = 256;
            3: len = $urandom_range(257, 511);
            default: len = $urandom_range(1, 256);
        endcase
        if (len >= 1 && len <= 256 && $urandom_range(0, 2) != 0)
            base = $urandom_range(0, 256 - len);
        else
            base = $urandom_range(0, 255);
        load_config(pick_colour() | upper_junk(24), pick_colour() | upper_junk(24),
                    pick_colour() | upper_junk(24), pick_cut() | upper_junk(17),
                    len | upper_junk(LEN_W), base | upper_junk(8));
    endtask

    initial begin : out_stall_driver
        int left;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                i_out_stall <= 1'b0;
                left = 0;
            end else if (left > 0) begin
                left--;
            end else if (i_out_stall) begin
                i_out_stall <= 1'b0;
                left = $urandom_range(0, 7);
            end else begin
                left = idle_len();
                if (left > 0) begin
                    i_out_stall <= 1'b1;
                    left--;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_entry('{o_palette_index, o_red, o_green, o_blue, o_out_of_range});
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int offsets[$];
        int len;
        int lim;
        sb = new;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // reset values of the registers
        offsets = '{0, 255};
        send_list(offsets);
        drain_results();

        // both spans, offsets around the cut and past the ramp
        load_config(32'hFF00FF, 32'h00FF80, 32'hFFFFFF, 32'h04000, 32'd200, 32'd0);
        offsets = '{0, 49, 50, 51, 199, 200, 255};
        send_list(offsets);
        drain_results();

        // cut at zero, single-entry ramp, base at the top of the palette
        load_config(32'h000000, 32'hFFFFFF, 32'h000000, 32'h00000, 32'd1, 32'd255);
        offsets = '{0, 1, 255};
        send_list(offsets);
        drain_results();

        // cut at one: the offset past the ramp lands on the empty upper span
        load_config(32'h123456, 32'hABCDEF, 32'hFEDCBA, 32'h10000, 32'd16, 32'd240);
        offsets = '{0, 15, 16};
        send_list(offsets);
        drain_results();

        // cut above one, zero length
        load_config(32'hFFFFFF, 32'h808080, 32'h000000, 32'h1FFFF, 32'd0, 32'd0);
        offsets = '{0, 255};
        send_list(offsets);
        drain_results();

        // longest length, smallest nonzero cut, junk above the field widths
        load_config(32'hFF000000, 32'hFFFFFFFF, 32'hAA000000, 32'hFFFE0001, 32'hFFFFFFFF,
                    32'h00000080);
        offsets = '{0, 1, 128, 255};
        send_list(offsets);
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_config(len);
            calm = (p == 2) || ($urandom_range(0, 3) == 0);
            lim  = (len > 256) ? 256 : len;
            for (int i = 0; i < PHASE_ITEMS + $urandom_range(0, 8); i++) begin
                if (lim > 0 && $urandom_range(0, 4) != 0)
                    send_offset(8'($urandom_range(0, lim - 1)));
                else
                    send_offset(8'($urandom_range(0, 255)));
            end
            drain_results();
            calm = 1'b0;
        end

        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d ramp entries, %0d of them flagged out of range,",
                 sb.checked, sb.flagged);
        $display("across %0d register settings including zero, one and over-range cuts.",
                 settings + 1);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
